@@ src/sfr_pkg.sv @@
// Shared types, constants and byte-class helpers for the stream find-and-replace block.
package sfr_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_CHARS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LEN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPLACE_CHARS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REPLACE_LEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IGNORE_CASE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WHOLE_WORD    = 3'd5;

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_REPL
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // append accepted beat to the window
      logic emit_head;  // send window head, drop one byte
      logic emit_rep;   // send current replacement byte
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic stop;        // window cannot be decided yet
      logic hit;         // pattern matches at the window head
      logic rep_final;   // current replacement byte is the last one
      logic stop_after;  // loop ends after the pending drop
      logic out_free;    // output register can take a byte
   } stat_type;

   function automatic logic [7:0] fold(input logic [7:0] c, input logic fold_en);
      if (fold_en && c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

@@ src/sfr_ctrl.sv @@
// Controller state machine: accept, evaluate the window head, send replacement bytes.
module sfr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sfr_pkg::stat_type   stat,
   output sfr_pkg::cmd_type    cmd
);

   sfr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_tready    = 1'b0;
      unique case (state_ff)
         sfr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = sfr_pkg::ST_EVAL;
            end
         end
         sfr_pkg::ST_EVAL: begin
            if (stat.stop) begin
               state_in = sfr_pkg::ST_IDLE;
            end else if (stat.out_free) begin
               if (stat.hit) begin
                  cmd.emit_rep = 1'b1;
                  if (!stat.rep_final) begin
                     state_in = sfr_pkg::ST_REPL;
                  end else if (stat.stop_after) begin
                     state_in = sfr_pkg::ST_IDLE;
                  end
               end else begin
                  cmd.emit_head = 1'b1;
                  if (stat.stop_after) begin
                     state_in = sfr_pkg::ST_IDLE;
                  end
               end
            end
         end
         sfr_pkg::ST_REPL: begin
            if (stat.out_free) begin
               cmd.emit_rep = 1'b1;
               if (stat.rep_final) begin
                  state_in = stat.stop_after ? sfr_pkg::ST_IDLE : sfr_pkg::ST_EVAL;
               end
            end
         end
         default: begin
            state_in = sfr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/sfr_datapath.sv @@
// Datapath: registers, byte window, match logic and output register.
module sfr_datapath #(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACE_MAX = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [7:0]                        req_char,
   input  logic                              req_last,
   input  logic                              csr_we,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [7:0]                        rsp_char,
   output logic                              rsp_run_last,
   output logic                              rsp_stream_end,
   input  sfr_pkg::cmd_type                  cmd,
   output sfr_pkg::stat_type                 stat
);

   localparam int WIN_DEPTH = PATTERN_MAX + 1;
   localparam int CNT_W = $clog2(WIN_DEPTH + 1);
   localparam int RLEN_W = $clog2(REPLACE_MAX + 1);
   localparam int RIDX_W = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

   // configuration
   logic [PATTERN_MAX*8-1:0] pat_ff;
   logic [3:0]               plen_raw_ff;
   logic [REPLACE_MAX*8-1:0] rep_ff;
   logic [3:0]               rlen_raw_ff;
   logic                     icase_ff;
   logic                     wword_ff;

   // stream state
   logic [7:0]       win_ff [WIN_DEPTH];
   logic [7:0]       win_in [WIN_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       bbw_ff, bbw_in;
   logic             last_ff;
   logic [RIDX_W-1:0] ridx_ff, ridx_in;

   // output register
   logic       ovalid_ff, ovalid_in;
   logic [7:0] ochar_ff;
   logic       orun_ff;
   logic       oend_ff;

   logic [CNT_W-1:0]  plen, need, remain, drop_n;
   logic [RLEN_W-1:0] rlen;
   logic              all_eq, hit, drop, run_last;
   logic [7:0]        after_byte, tail_byte, rep_byte;

   always_comb begin
      if (plen_raw_ff == 4'd0) begin
         plen = CNT_W'(1);
      end else if (plen_raw_ff > 4'(PATTERN_MAX)) begin
         plen = CNT_W'(PATTERN_MAX);
      end else begin
         plen = CNT_W'(plen_raw_ff);
      end
      if (rlen_raw_ff == 4'd0) begin
         rlen = RLEN_W'(1);
      end else if (rlen_raw_ff > 4'(REPLACE_MAX)) begin
         rlen = RLEN_W'(REPLACE_MAX);
      end else begin
         rlen = RLEN_W'(rlen_raw_ff);
      end
   end

   assign need = plen + CNT_W'(wword_ff);

   // compare the window head against the pattern
   always_comb begin
      all_eq     = 1'b1;
      after_byte = sfr_pkg::SPACE_CHAR;
      tail_byte  = win_ff[0];
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (CNT_W'(i) < plen &&
             sfr_pkg::fold(win_ff[i], icase_ff) !=
             sfr_pkg::fold(pat_ff[i*8 +: 8], icase_ff)) begin
            all_eq = 1'b0;
         end
         if (CNT_W'(i + 1) == plen) begin
            tail_byte = win_ff[i];
            if (count_ff > plen) begin
               after_byte = win_ff[i + 1];
            end
         end
      end
      hit = (count_ff >= plen) && all_eq &&
            !(wword_ff && (sfr_pkg::is_alnum(bbw_ff) || sfr_pkg::is_alnum(after_byte)));
   end

   always_comb begin
      rep_byte = rep_ff[7:0];
      for (int i = 0; i < REPLACE_MAX; i++) begin
         if (RIDX_W'(i) == ridx_ff) begin
            rep_byte = rep_ff[i*8 +: 8];
         end
      end
   end

   assign remain = hit ? (count_ff - plen) : (count_ff - CNT_W'(1));

   assign stat.stop       = !last_ff && (count_ff < need);
   assign stat.hit        = hit;
   assign stat.rep_final  = (ridx_ff == RIDX_W'(rlen - RLEN_W'(1)));
   assign stat.stop_after = (remain == '0) || (!last_ff && (remain < need));
   assign stat.out_free   = !ovalid_ff || rsp_tready;

   assign drop     = cmd.emit_head || (cmd.emit_rep && stat.rep_final);
   assign drop_n   = cmd.emit_head ? CNT_W'(1) : plen;
   assign run_last = drop && stat.stop_after;

   // window next state: append on load, shift out on drop
   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         win_in[i] = win_ff[i];
      end
      if (cmd.load) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            if (CNT_W'(i) == count_ff) begin
               win_in[i] = req_char;
            end
         end
      end else if (drop) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            for (int s = 1; s < WIN_DEPTH - i; s++) begin
               if (CNT_W'(s) == drop_n) begin
                  win_in[i] = win_ff[i + s];
               end
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      bbw_in   = bbw_ff;
      ridx_in  = ridx_ff;
      if (cmd.load) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.emit_rep) begin
         ridx_in = stat.rep_final ? '0 : ridx_ff + RIDX_W'(1);
      end
      if (drop) begin
         count_in = remain;
         bbw_in   = cmd.emit_head ? win_ff[0] : tail_byte;
         if (run_last && last_ff) begin
            bbw_in = sfr_pkg::SPACE_CHAR;
         end
      end
      // a write to any defined register (index 0 to 5) ends the stream: drop pending bytes
      if (csr_we && csr_index <= sfr_pkg::REG_WHOLE_WORD) begin
         count_in = '0;
         bbw_in   = sfr_pkg::SPACE_CHAR;
         ridx_in  = '0;
      end
   end

   always_comb begin
      ovalid_in = ovalid_ff;
      if (cmd.emit_head || cmd.emit_rep) begin
         ovalid_in = 1'b1;
      end else if (rsp_tready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff      <= '0;
         plen_raw_ff <= 4'd1;
         rep_ff      <= '0;
         rlen_raw_ff <= 4'd1;
         icase_ff    <= 1'b0;
         wword_ff    <= 1'b0;
         count_ff    <= '0;
         bbw_ff      <= sfr_pkg::SPACE_CHAR;
         ridx_ff     <= '0;
         ovalid_ff   <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         count_ff  <= count_in;
         bbw_ff    <= bbw_in;
         ridx_ff   <= ridx_in;
         ovalid_ff <= ovalid_in;
         if (cmd.load) begin
            last_ff <= req_last;
         end
         if (csr_we) begin
            unique case (csr_index)
               sfr_pkg::REG_PATTERN_CHARS: pat_ff      <= csr_wdata[PATTERN_MAX*8-1:0];
               sfr_pkg::REG_PATTERN_LEN:   plen_raw_ff <= csr_wdata[3:0];
               sfr_pkg::REG_REPLACE_CHARS: rep_ff      <= csr_wdata[REPLACE_MAX*8-1:0];
               sfr_pkg::REG_REPLACE_LEN:   rlen_raw_ff <= csr_wdata[3:0];
               sfr_pkg::REG_IGNORE_CASE:   icase_ff    <= csr_wdata[0];
               sfr_pkg::REG_WHOLE_WORD:    wword_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         win_ff[i] <= win_in[i];
      end
      if (cmd.emit_head || cmd.emit_rep) begin
         ochar_ff <= cmd.emit_head ? win_ff[0] : rep_byte;
         orun_ff  <= run_last;
         oend_ff  <= run_last && last_ff;
      end
   end

   assign rsp_tvalid     = ovalid_ff;
   assign rsp_char       = ochar_ff;
   assign rsp_run_last   = orun_ff;
   assign rsp_stream_end = oend_ff;

endmodule

@@ src/stream_find_replace.sv @@
// Top level of the streaming find-and-replace block.
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  req_     | in        | tdata = in_char, tlast = in_last
//  rsp_     | out       | tdata = out_char, tlast = run_last, tuser = stream_end
//  csr_     | in        | write enable, register index, 64-bit write data
//
// Each input beat is accepted, then the window head is evaluated one
// decision step at a time: a step passes one byte through or sends the
// replacement bytes one by one; the beat is done when the window can no
// longer be decided, and no new beat is accepted until then. Reset is
// synchronous; it clears the configuration, counters and output valid flag
// and empties the window, but not the window or output data bytes. A stalled
// rsp_ side holds the output register and freezes evaluation until it is taken.
module stream_find_replace #(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACE_MAX = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] in_char
   input  logic                            req_tlast,   // in_last
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] out_char
   output logic                            rsp_tlast,   // run_last
   output logic                            rsp_tuser,   // [0] stream_end
   // configuration writes
   input  logic                            csr_we,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   sfr_pkg::cmd_type  cmd;
   sfr_pkg::stat_type stat;

   // sequence one beat at a time: load, then evaluate the head until undecided
   sfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // hold window, registers, match logic and the output register
   sfr_datapath #(
      .PATTERN_MAX (PATTERN_MAX),
      .REPLACE_MAX (REPLACE_MAX)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_char       (req_tdata),
      .req_last       (req_tlast),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_char       (rsp_tdata),
      .rsp_run_last   (rsp_tlast),
      .rsp_stream_end (rsp_tuser),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule
